FILE: sv/gte_pkg.sv
// Shared types and constants for the graph traversal engine.
// No dependencies; the files that use it refer to it by scoped names.
package gte_pkg;

  localparam int VERTICES_DEF = 16;   // default vertex count
  localparam int FIELD_W      = 4;    // width of a vertex field on the ports
  localparam int CMD_W        = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BFS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DFS = 2'd2;

  // one accepted input word
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] first_vertex;
    logic [FIELD_W-1:0] second_vertex;
  } cmd_t;

  // one result word handed from the controller to the output register
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] vertex;
    logic               last;
  } emit_t;

endpackage

FILE: sv/gte_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. Standalone, no package use.
module gte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/gte_out.sv
// Output register of the traversal engine: holds one result word until taken.
// Depends on gte_pkg (emit_t).
module gte_out (
  input  logic                         clk,
  input  logic                         rst,
  input  gte_pkg::emit_t               emit,
  output logic                         free,
  output logic                         tvalid,
  input  logic                         tready,
  output logic [gte_pkg::FIELD_W-1:0]  vertex,
  output logic                         last
);

  assign free = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (emit.valid) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      vertex <= emit.vertex;
      last   <= emit.last;
    end
  end

endmodule

FILE: sv/gte_ctrl.sv
// Traversal controller: adjacency RAM, queue/stack RAM and the sequencer.
// Depends on gte_pkg and gte_ram.
module gte_ctrl #(
  parameter int VERTICES = gte_pkg::VERTICES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gte_pkg::cmd_t  cmd,
  input  logic           out_free,
  output gte_pkg::emit_t emit
);

  localparam int VW = $clog2(VERTICES);
  localparam int CW = VW + 1;
  localparam int XW = VW + gte_pkg::FIELD_W;
  localparam logic [VERTICES-1:0] ONE = VERTICES'(1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ADD_WA   = 4'd1;
  localparam logic [3:0] ST_ADD_WB   = 4'd2;
  localparam logic [3:0] ST_BFS_POP  = 4'd3;
  localparam logic [3:0] ST_BFS_ROW  = 4'd4;
  localparam logic [3:0] ST_BFS_SCAN = 4'd5;
  localparam logic [3:0] ST_DFS_RD   = 4'd6;
  localparam logic [3:0] ST_DFS_ROW  = 4'd7;
  localparam logic [3:0] ST_DFS_SCAN = 4'd8;
  localparam logic [3:0] ST_FLUSH    = 4'd9;

  logic [3:0]          state, state_next;
  logic [VERTICES-1:0] marks, marks_next;
  logic [VERTICES-1:0] row_valid, row_valid_next;
  logic [CW-1:0]       head, head_next;
  logic [CW-1:0]       tail, tail_next;
  logic [CW-1:0]       sp, sp_next;
  logic [CW-1:0]       sp_m1;
  logic [VW-1:0]       pend, pend_next;
  logic                pend_valid, pend_valid_next;
  logic [VW-1:0]       ea, eb;
  logic                adj_rvalid;

  logic                adj_we, adj_re;
  logic [VW-1:0]       adj_waddr, adj_raddr;
  logic [VERTICES-1:0] adj_wdata, adj_rdata, adj_row;
  logic                vq_we, vq_re;
  logic [VW-1:0]       vq_waddr, vq_raddr, vq_wdata, vq_rdata;

  logic [XW-1:0]       ext_a, ext_b, ext_p;
  logic [VW-1:0]       in_a, in_b;
  logic                a_ok, b_ok, in_fire;
  logic [VERTICES-1:0] cand;
  logic                cand_any;
  logic [VW-1:0]       low;

  gte_ram #(.WIDTH(VERTICES), .DEPTH(VERTICES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
  );

  // BFS queue and DFS stack share one store; only one traversal runs at a time
  gte_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_vq (
    .clk(clk), .we(vq_we), .waddr(vq_waddr), .wdata(vq_wdata),
    .re(vq_re), .raddr(vq_raddr), .rdata(vq_rdata)
  );

  assign ext_a = {{VW{1'b0}}, cmd.first_vertex};
  assign ext_b = {{VW{1'b0}}, cmd.second_vertex};
  assign in_a  = ext_a[VW-1:0];
  assign in_b  = ext_b[VW-1:0];
  assign a_ok  = ext_a < XW'(VERTICES);
  assign b_ok  = ext_b < XW'(VERTICES);
  assign ext_p = {{gte_pkg::FIELD_W{1'b0}}, pend};
  assign sp_m1 = sp - CW'(1);
  assign in_fire = in_valid && in_ready;

  // rows never written read as zero
  assign adj_row  = adj_rvalid ? adj_rdata : '0;
  assign cand     = adj_row & ~marks;
  assign cand_any = |cand;

  // lowest unvisited neighbor
  always_comb begin
    low = '0;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        low = VW'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    marks_next      = marks;
    row_valid_next  = row_valid;
    head_next       = head;
    tail_next       = tail;
    sp_next         = sp;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    in_ready        = 1'b0;
    adj_we          = 1'b0;
    adj_waddr       = ea;
    adj_wdata       = '0;
    adj_re          = 1'b0;
    adj_raddr       = in_a;
    vq_we           = 1'b0;
    vq_waddr        = '0;
    vq_wdata        = in_a;
    vq_re           = 1'b0;
    vq_raddr        = head[VW-1:0];
    emit.valid      = 1'b0;
    emit.vertex     = ext_p[gte_pkg::FIELD_W-1:0];
    emit.last       = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd.command)
            gte_pkg::CMD_ADD: begin
              if (a_ok && b_ok) begin
                adj_re     = 1'b1;
                state_next = ST_ADD_WA;
              end
            end
            gte_pkg::CMD_BFS: begin
              if (a_ok) begin
                marks_next = ONE << in_a;
                vq_we      = 1'b1;
                head_next  = '0;
                tail_next  = CW'(1);
                state_next = ST_BFS_POP;
              end
            end
            gte_pkg::CMD_DFS: begin
              if (a_ok) begin
                marks_next      = ONE << in_a;
                pend_next       = in_a;
                pend_valid_next = 1'b1;
                vq_we           = 1'b1;
                sp_next         = CW'(1);
                adj_re          = 1'b1;
                state_next      = ST_DFS_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // read-modify-write of both rows; a self loop reads the old row twice
      // and writes the same value twice
      ST_ADD_WA: begin
        adj_we            = 1'b1;
        adj_waddr         = ea;
        adj_wdata         = adj_row | (ONE << eb);
        row_valid_next[ea] = 1'b1;
        adj_re            = 1'b1;
        adj_raddr         = eb;
        state_next        = ST_ADD_WB;
      end

      ST_ADD_WB: begin
        adj_we            = 1'b1;
        adj_waddr         = eb;
        adj_wdata         = adj_row | (ONE << ea);
        row_valid_next[eb] = 1'b1;
        state_next        = ST_IDLE;
      end

      ST_BFS_POP: begin
        if (head == tail) begin
          state_next = ST_FLUSH;
        end else begin
          vq_re      = 1'b1;
          vq_raddr   = head[VW-1:0];
          head_next  = head + CW'(1);
          state_next = ST_BFS_ROW;
        end
      end

      ST_BFS_ROW: begin
        if (!pend_valid || out_free) begin
          emit.valid      = pend_valid;
          pend_next       = vq_rdata;
          pend_valid_next = 1'b1;
          adj_re          = 1'b1;
          adj_raddr       = vq_rdata;
          state_next      = ST_BFS_SCAN;
        end
      end

      // one newly found neighbor enqueued per cycle
      ST_BFS_SCAN: begin
        if (cand_any) begin
          vq_we      = 1'b1;
          vq_waddr   = tail[VW-1:0];
          vq_wdata   = low;
          tail_next  = tail + CW'(1);
          marks_next = marks | (ONE << low);
        end else begin
          state_next = ST_BFS_POP;
        end
      end

      ST_DFS_RD: begin
        vq_re      = 1'b1;
        vq_raddr   = sp_m1[VW-1:0];
        state_next = ST_DFS_ROW;
      end

      ST_DFS_ROW: begin
        adj_re     = 1'b1;
        adj_raddr  = vq_rdata;
        state_next = ST_DFS_SCAN;
      end

      // marks only grow, so rescanning a row from zero finds the same
      // neighbor as resuming after the last one taken
      ST_DFS_SCAN: begin
        if (cand_any) begin
          if (!pend_valid || out_free) begin
            emit.valid      = pend_valid;
            pend_next       = low;
            pend_valid_next = 1'b1;
            marks_next      = marks | (ONE << low);
            vq_we           = 1'b1;
            vq_waddr        = sp[VW-1:0];
            vq_wdata        = low;
            sp_next         = sp + CW'(1);
            adj_re          = 1'b1;
            adj_raddr       = low;
          end
        end else begin
          sp_next    = sp_m1;
          state_next = (sp == CW'(1)) ? ST_FLUSH : ST_DFS_RD;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          emit.valid      = 1'b1;
          emit.last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      marks      <= '0;
      row_valid  <= '0;
      head       <= '0;
      tail       <= '0;
      sp         <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      marks      <= marks_next;
      row_valid  <= row_valid_next;
      head       <= head_next;
      tail       <= tail_next;
      sp         <= sp_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (in_fire) begin
      ea <= in_a;
      eb <= in_b;
    end
    if (adj_re) begin
      adj_rvalid <= row_valid[adj_raddr];
    end
  end

`ifndef SYNTHESIS
  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst) sp <= CW'(VERTICES))
    else $error("stack depth beyond vertex count");
  a_emit_free: assert property (@(posedge clk) disable iff (rst) emit.valid |-> out_free)
    else $error("result word issued into a full output register");
  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FLUSH) |-> pend_valid)
    else $error("flush without a pending vertex");
  a_start_mark: assert property (@(posedge clk) disable iff (rst)
      (in_fire && a_ok &&
       (cmd.command == gte_pkg::CMD_BFS || cmd.command == gte_pkg::CMD_DFS))
      |=> $onehot(marks))
    else $error("traversal start did not leave exactly one mark");
`endif

endmodule

FILE: sv/graph_traversal_engine_top.sv
// Graph traversal engine: add-edge, BFS and DFS over an adjacency bit matrix.
// Add edge: read row a, write row a while reading row b, write row b; no result word.
// BFS: per visited vertex a queue read and a row read, then one enqueued neighbor
// per scan cycle; DFS: per visited vertex one scan, per backtrack a stack read,
// a row read and a rescan. One item at a time; a new command is taken only when idle.
// Reset: synchronous, active high; clears control, marks and row valid flags.
//
// Depends on gte_pkg, gte_ram, gte_ctrl and gte_out.
module graph_traversal_engine_top #(
  parameter int VERTICES = gte_pkg::VERTICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] first_vertex, [7:4] second_vertex
  input  logic [1:0] s_axis_tuser,   // [1:0] command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] visited_vertex, [7:4] zero
  output logic       m_axis_tlast    // last vertex of a traversal
);

  gte_pkg::cmd_t  cmd;
  gte_pkg::emit_t emit;
  logic           out_free;
  logic [gte_pkg::FIELD_W-1:0] out_vertex;

  assign cmd.command       = s_axis_tuser;
  assign cmd.first_vertex  = s_axis_tdata[3:0];
  assign cmd.second_vertex = s_axis_tdata[7:4];

  // Sequencer and both RAMs. Adjacency rows that were never written read
  // as zero through per-row valid flags, so no clearing pass is needed.
  gte_ctrl #(.VERTICES(VERTICES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .out_free (out_free),
    .emit     (emit)
  );

  // Output register decouples the downstream ready from the sequencer;
  // the sequencer stalls only when it must hand over a word and this is full.
  gte_out u_out (
    .clk    (clk),
    .rst    (rst),
    .emit   (emit),
    .free   (out_free),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .vertex (out_vertex),
    .last   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_vertex};

endmodule
